@@ rtl/nme_pkg.sv @@
// shared types, constants and helpers of the note to midi event encoder
package nme_pkg;

  localparam int unsigned OCTAVE_ROWS = 11;

  localparam int unsigned IN_W  = 48;
  localparam int unsigned OUT_W = 88;
  localparam int unsigned NUM_BYTES = 10;

  localparam logic [1:0] FUNC_CHAR = 2'd0;
  localparam logic [1:0] FUNC_SET  = 2'd1;
  localparam logic [1:0] FUNC_EMIT = 2'd2;

  localparam logic [1:0] CFG_CHANNEL = 2'd0;
  localparam logic [1:0] CFG_VEL_ON  = 2'd1;
  localparam logic [1:0] CFG_VEL_OFF = 2'd2;

  localparam logic [7:0] CHAR_DIGIT_LO = 8'h31;
  localparam logic [7:0] CHAR_DIGIT_HI = 8'h37;
  localparam logic [7:0] CHAR_H_LOWER  = 8'h68;
  localparam logic [7:0] CHAR_H_UPPER  = 8'h48;
  localparam logic [7:0] CHAR_L_LOWER  = 8'h6C;
  localparam logic [7:0] CHAR_L_UPPER  = 8'h4C;
  localparam logic [7:0] CHAR_B_LOWER  = 8'h62;
  localparam logic [7:0] CHAR_B_UPPER  = 8'h42;
  localparam logic [7:0] CHAR_SHARP    = 8'h23;

  localparam logic [3:0] ROW_MAX     = 4'(OCTAVE_ROWS - 1);
  localparam logic [3:0] COL_MAX     = 4'd15;
  localparam logic [3:0] ROW_RESET   = 4'd5;
  localparam logic [3:0] COL_RESET   = 4'd0;
  localparam logic [7:0] PITCH_RESET = 8'd60;
  localparam logic [7:0] PITCH_MAX   = 8'd131;

  localparam logic [15:0] HOLD_MAX   = 16'd16383;
  localparam logic [7:0]  STATUS_ON  = 8'h90;
  localparam logic [7:0]  STATUS_OFF = 8'h80;
  localparam logic [7:0]  VLQ_CONT   = 8'h80;
  localparam logic [6:0]  DATA_MASK  = 7'h7F;

  localparam logic [3:0] CNT_BASE      = 4'd8;
  localparam logic [3:0] CNT_MAX       = 4'd10;
  localparam logic [3:0] CHAN_RESET    = 4'd0;
  localparam logic [6:0] VON_RESET     = 7'd100;
  localparam logic [6:0] VOFF_RESET    = 7'd64;

  typedef struct packed {
    logic [3:0] channel;
    logic [6:0] vel_on;
    logic [6:0] vel_off;
  } nme_cfg_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] func;
    logic [7:0] char_code;
    logic [3:0] row_in;
    logic [3:0] col_in;
  } nme_upd_t;

  typedef struct packed {
    logic [3:0]                     byte_count;
    logic [NUM_BYTES-1:0][7:0]      bytes;
  } nme_result_t;

  function automatic logic [3:0] digit_col(input logic [2:0] d);
    logic [3:0] c;
    case (d)
      3'd1:    c = 4'd0;
      3'd2:    c = 4'd2;
      3'd3:    c = 4'd4;
      3'd4:    c = 4'd5;
      3'd5:    c = 4'd7;
      3'd6:    c = 4'd9;
      3'd7:    c = 4'd11;
      default: c = 4'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pitch_of(input logic [3:0] row, input logic [3:0] col);
    logic [7:0] p;
    p = {1'b0, row, 3'b000} + {2'b00, row, 2'b00} + {4'b0000, col};
    return (p > PITCH_MAX) ? PITCH_MAX : p;
  endfunction

endpackage

@@ rtl/nme_pitch_track.sv @@
// octave row, scale column and pitch state with its update logic
module nme_pitch_track import nme_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  nme_upd_t   upd_i,
  output logic [7:0] pitch_o
);

  logic [3:0] row_q, row_d;
  logic [3:0] col_q, col_d;
  logic [7:0] pitch_q, pitch_d;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    case (upd_i.func)
      FUNC_CHAR: begin
        case (upd_i.char_code) inside
          [CHAR_DIGIT_LO:CHAR_DIGIT_HI]: col_d = digit_col(upd_i.char_code[2:0]);
          CHAR_H_LOWER, CHAR_H_UPPER: begin
            if (row_q < ROW_MAX) row_d = row_q + 4'd1;
          end
          CHAR_L_LOWER, CHAR_L_UPPER: begin
            if (row_q != 4'd0) row_d = row_q - 4'd1;
          end
          CHAR_B_LOWER, CHAR_B_UPPER, CHAR_SHARP: begin
            if (col_q != COL_MAX) col_d = col_q + 4'd1;
          end
          default: ;
        endcase
      end
      FUNC_SET: begin
        row_d = (upd_i.row_in > ROW_MAX) ? ROW_MAX : upd_i.row_in;
        col_d = upd_i.col_in;
      end
      default: ;
    endcase
    pitch_d = pitch_of(row_d, col_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= ROW_RESET;
      col_q   <= COL_RESET;
      pitch_q <= PITCH_RESET;
    end else if (upd_i.valid) begin
      row_q   <= row_d;
      col_q   <= col_d;
      pitch_q <= pitch_d;
    end
  end

  assign pitch_o = pitch_q;

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= ROW_MAX) else $error("octave row out of range");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pitch_q <= PITCH_MAX) else $error("pitch above limit");

  a_pitch_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pitch_q == pitch_of(row_q, col_q)) else $error("pitch does not follow row and column");

endmodule

@@ rtl/nme_event_pack.sv @@
// packs delay, note-on, hold and note-off into one event word
module nme_event_pack import nme_pkg::*; (
  input  logic [13:0]  delay_i,
  input  logic [15:0]  hold_i,
  input  logic [7:0]   pitch_i,
  input  nme_cfg_t     cfg_i,
  output nme_result_t  res_o
);

  logic [13:0] hold_sat;
  logic        d_two, h_two;
  logic [3:0]  pos;

  always_comb begin
    hold_sat = (hold_i > HOLD_MAX) ? HOLD_MAX[13:0] : hold_i[13:0];
    d_two    = (delay_i[13:7] != 7'd0);
    h_two    = (hold_sat[13:7] != 7'd0);

    res_o.bytes = '0;
    pos = 4'd0;
    if (d_two) begin
      res_o.bytes[pos] = VLQ_CONT | {1'b0, delay_i[13:7]};
      pos = pos + 4'd1;
    end
    res_o.bytes[pos]        = {1'b0, delay_i[6:0] & DATA_MASK};
    res_o.bytes[pos + 4'd1] = STATUS_ON | {4'h0, cfg_i.channel};
    res_o.bytes[pos + 4'd2] = pitch_i;
    res_o.bytes[pos + 4'd3] = {1'b0, cfg_i.vel_on};
    pos = pos + 4'd4;
    if (h_two) begin
      res_o.bytes[pos] = VLQ_CONT | {1'b0, hold_sat[13:7]};
      pos = pos + 4'd1;
    end
    res_o.bytes[pos]        = {1'b0, hold_sat[6:0] & DATA_MASK};
    res_o.bytes[pos + 4'd1] = STATUS_OFF | {4'h0, cfg_i.channel};
    res_o.bytes[pos + 4'd2] = pitch_i;
    res_o.bytes[pos + 4'd3] = {1'b0, cfg_i.vel_off};

    res_o.byte_count = CNT_BASE + {3'b000, d_two} + {3'b000, h_two};
  end

endmodule

@@ rtl/note_to_midi_event_encoder_top.sv @@
// top level of the note to midi event encoder: input stage, state, packer, output stage
// an emit word passes the input stage register and then the output stage register to the master side
// throughput: one word per cycle, ready drops only while both stages hold stalled words
// note and set words pass the input stage register, then update the pitch state, and give no output
// reset: asynchronous active low, clears both stages, sets row 5, column 0, pitch 60,
// channel 0, note-on velocity 100 and note-off velocity 64
module note_to_midi_event_encoder_top import nme_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // func[1:0]
  input  logic [1:0]       s_axis_tuser,
  // char_code[7:0], row_in[11:8], col_in[15:12],
  // delay_ticks[29:16], hold_ticks[45:30], zero fill [47:46]
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // byte0[7:0] .. byte9[79:72], byte_count[83:80], zero fill [87:84]
  output logic [OUT_W-1:0] m_axis_tdata,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [6:0]       cfg_data_i
);

  nme_cfg_t        cfg_q;
  logic            s_vld_q;
  logic [IN_W-1:0] s_word_q;
  logic [1:0]      s_user_q;
  logic            out_vld_q, out_vld_d;
  nme_result_t     out_q;

  logic [1:0]  s_func;
  logic [7:0]  s_char;
  logic [3:0]  s_row;
  logic [3:0]  s_col;
  logic [13:0] s_delay;
  logic [15:0] s_hold;
  logic        out_free, s_is_emit, s_adv, s_emit_adv;
  logic [7:0]  pitch;
  nme_upd_t    upd;
  nme_result_t res;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel <= CHAN_RESET;
      cfg_q.vel_on  <= VON_RESET;
      cfg_q.vel_off <= VOFF_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHANNEL: cfg_q.channel <= cfg_data_i[3:0];
        CFG_VEL_ON:  cfg_q.vel_on  <= cfg_data_i;
        CFG_VEL_OFF: cfg_q.vel_off <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input stage
  assign s_func  = s_user_q;
  assign s_char  = s_word_q[7:0];
  assign s_row   = s_word_q[11:8];
  assign s_col   = s_word_q[15:12];
  assign s_delay = s_word_q[29:16];
  assign s_hold  = s_word_q[45:30];

  assign out_free   = !out_vld_q || m_axis_tready;
  assign s_is_emit  = (s_func == FUNC_EMIT);
  assign s_adv      = s_vld_q && (!s_is_emit || out_free);
  assign s_emit_adv = s_vld_q && s_is_emit && out_free;
  assign s_axis_tready = !s_vld_q || s_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      s_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s_word_q <= s_axis_tdata;
      s_user_q <= s_axis_tuser;
    end
  end

  // pitch state
  always_comb begin
    upd.valid     = s_adv && !s_is_emit;
    upd.func      = s_func;
    upd.char_code = s_char;
    upd.row_in    = s_row;
    upd.col_in    = s_col;
  end

  nme_pitch_track u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (upd),
    .pitch_o (pitch)
  );

  nme_event_pack u_pack (
    .delay_i (s_delay),
    .hold_i  (s_hold),
    .pitch_i (pitch),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  // output stage
  always_comb begin
    out_vld_d = out_vld_q;
    if (s_emit_adv) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_emit_adv) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'h0, out_q};

  a_emit_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_emit_adv |=> m_axis_tvalid) else $error("emit word lost");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.byte_count >= CNT_BASE && out_q.byte_count <= CNT_MAX))
    else $error("byte count out of range");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.byte_count == CNT_BASE) |->
      (out_q.bytes[8] == 8'h00 && out_q.bytes[9] == 8'h00))
    else $error("unused bytes not cleared");

  a_no_state_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_emit_adv |=> $stable(pitch)) else $error("emit changed pitch state");

endmodule

@@ tb/tb.sv @@
// testbench for the note to midi event encoder: directed and random words checked in order
`timescale 1ns / 100ps

module tb;
  import nme_pkg::*;

  localparam logic [1:0] FUNC_UNUSED  = 2'd3;
  localparam logic [7:0] CHAR_M_LOWER = 8'h6D;
  localparam logic [7:0] CHAR_M_UPPER = 8'h4D;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned WORDS_PER_PHASE = 315;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CHOKE, RX_EVERY_THIRD} rx_mode_e;

  logic             clk;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [1:0]       s_axis_tuser;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [6:0]       cfg_data_i;

  // pitch state and register copies
  logic [3:0] row_st;
  logic [3:0] col_st;
  logic [7:0] pitch_st;
  logic [3:0] chan_cfg;
  logic [6:0] von_cfg;
  logic [6:0] voff_cfg;

  nme_result_t pending_events[$];
  int          err_count;
  int          burst_left;
  bit          calm;
  rx_mode_e    rx_mode;
  int          rx_left;
  int          rx_tick;

  note_to_midi_event_encoder_top u_top (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk = ~clk;

  function automatic logic [7:0] clipped_pitch(input logic [3:0] row, input logic [3:0] col);
    int p;
    p = int'(row) * 12 + int'(col);
    if (p > int'(PITCH_MAX)) begin
      p = int'(PITCH_MAX);
    end
    return 8'(p);
  endfunction

  function automatic void update_pitch_state(input logic [1:0] kind, input logic [7:0] glyph,
                                             input logic [3:0] set_row, input logic [3:0] set_col);
    logic [3:0] scale_col [7];
    scale_col = '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11};
    if (kind == FUNC_CHAR) begin
      if (glyph >= CHAR_DIGIT_LO && glyph <= CHAR_DIGIT_HI) begin
        col_st = scale_col[glyph - CHAR_DIGIT_LO];
      end else if (glyph == CHAR_H_LOWER || glyph == CHAR_H_UPPER) begin
        if (row_st < ROW_MAX) row_st = row_st + 4'd1;
      end else if (glyph == CHAR_L_LOWER || glyph == CHAR_L_UPPER) begin
        if (row_st > 4'd0) row_st = row_st - 4'd1;
      end else if (glyph == CHAR_B_LOWER || glyph == CHAR_B_UPPER || glyph == CHAR_SHARP) begin
        if (col_st < COL_MAX) col_st = col_st + 4'd1;
      end
      pitch_st = clipped_pitch(row_st, col_st);
    end else if (kind == FUNC_SET) begin
      row_st   = (set_row > ROW_MAX) ? ROW_MAX : set_row;
      col_st   = set_col;
      pitch_st = clipped_pitch(row_st, col_st);
    end
  endfunction

  function automatic nme_result_t midi_event_of(input logic [13:0] pre_ticks,
                                                input logic [15:0] dur_ticks);
    nme_result_t r;
    logic [13:0] v;
    int n;
    r = '0;
    n = 0;
    for (int e = 0; e < 2; e++) begin
      if (e == 0) begin
        v = pre_ticks;
      end else begin
        v = (dur_ticks > HOLD_MAX) ? 14'(HOLD_MAX) : dur_ticks[13:0];
      end
      if (v >= 14'd128) begin
        r.bytes[n] = VLQ_CONT | {1'b0, v[13:7]};
        n++;
      end
      r.bytes[n] = {1'b0, v[6:0] & DATA_MASK};
      n++;
      r.bytes[n] = ((e == 0) ? STATUS_ON : STATUS_OFF) | {4'd0, chan_cfg};
      n++;
      r.bytes[n] = pitch_st;
      n++;
      r.bytes[n] = {1'b0, (e == 0) ? von_cfg : voff_cfg};
      n++;
    end
    r.byte_count = 4'(n);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  task automatic send_word(input logic [1:0] kind, input logic [7:0] glyph,
                           input logic [3:0] set_row, input logic [3:0] set_col,
                           input logic [13:0] pre_ticks, input logic [15:0] dur_ticks);
    int gap;
    if (burst_left == 0) begin
      gap = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, dur_ticks, pre_ticks, set_col, set_row, glyph};
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    if (kind == FUNC_EMIT) begin
      pending_events.push_back(midi_event_of(pre_ticks, dur_ticks));
    end else begin
      update_pitch_state(kind, glyph, set_row, set_col);
    end
  endtask

  task automatic drain;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    // note and set words may still be in flight
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] value);
    @(negedge clk);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_CHANNEL: chan_cfg = value[3:0];
      CFG_VEL_ON:  von_cfg  = value;
      CFG_VEL_OFF: voff_cfg = value;
      default: ;
    endcase
  endtask

  task automatic send_random_word;
    logic [1:0]  kind;
    logic [7:0]  glyph;
    logic [13:0] pre_ticks;
    logic [15:0] dur_ticks;
    logic [7:0]  note_glyphs [10];
    int pick;
    note_glyphs = '{CHAR_H_LOWER, CHAR_H_UPPER, CHAR_L_LOWER, CHAR_L_UPPER, CHAR_B_LOWER,
                    CHAR_B_UPPER, CHAR_SHARP, CHAR_M_LOWER, CHAR_M_UPPER, CHAR_DIGIT_LO};
    pick = $urandom_range(0, 99);
    glyph = 8'($urandom_range(0, 255));
    if (pick < 45) begin
      kind = FUNC_CHAR;
      if (pick < 22) begin
        glyph = CHAR_DIGIT_LO + 8'($urandom_range(0, 6));
      end else if (pick < 38) begin
        glyph = note_glyphs[$urandom_range(0, 9)];
      end
    end else if (pick < 58) begin
      kind = FUNC_SET;
    end else if (pick < 95) begin
      kind = FUNC_EMIT;
    end else begin
      kind = FUNC_UNUSED;
    end
    case ($urandom_range(0, 2))
      0: pre_ticks = 14'($urandom_range(0, 127));
      1: pre_ticks = 14'($urandom_range(126, 129));
      default: pre_ticks = 14'($urandom_range(0, 16383));
    endcase
    case ($urandom_range(0, 3))
      0: dur_ticks = 16'($urandom_range(0, 127));
      1: dur_ticks = 16'($urandom_range(16382, 16385));
      2: dur_ticks = 16'($urandom_range(126, 129));
      default: dur_ticks = 16'($urandom_range(0, 65535));
    endcase
    send_word(kind, glyph, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
              pre_ticks, dur_ticks);
  endtask

  task automatic test_reset_state;
    send_word(FUNC_EMIT, 8'h00, 4'd0, 4'd0, 14'd0, 16'd0);
    send_word(FUNC_CHAR, CHAR_DIGIT_HI, 4'd0, 4'd0, 14'd0, 16'd0);
    send_word(FUNC_EMIT, 8'h00, 4'd0, 4'd0, 14'd127, 16'd127);
  endtask

  task automatic test_pitch_limits;
    // top row holds, then pitch clips at the ceiling
    send_word(FUNC_SET, 8'h00, 4'd9, 4'd0, 14'd0, 16'd0);
    send_word(FUNC_CHAR, CHAR_H_LOWER, 4'd0, 4'd0, 14'd0, 16'd0);
    send_word(FUNC_CHAR, CHAR_H_UPPER, 4'd0, 4'd0, 14'd0, 16'd0);
    send_word(FUNC_CHAR, CHAR_SHARP, 4'd0, 4'd0, 14'd0, 16'd0);
    send_word(FUNC_EMIT, 8'h00, 4'd0, 4'd0, 14'd128, 16'd128);
    send_word(FUNC_SET, 8'h00, 4'd15, 4'd15, 14'd0, 16'd0);
    send_word(FUNC_CHAR, CHAR_B_LOWER, 4'd0, 4'd0, 14'd0, 16'd0);
    send_word(FUNC_EMIT, 8'h00, 4'd0, 4'd0, 14'd16383, 16'd65535);
    // bottom row holds
    send_word(FUNC_SET, 8'h00, 4'd0, 4'd0, 14'd0, 16'd0);
    send_word(FUNC_CHAR, CHAR_L_LOWER, 4'd0, 4'd0, 14'd0, 16'd0);
    send_word(FUNC_CHAR, CHAR_L_UPPER, 4'd0, 4'd0, 14'd0, 16'd0);
    send_word(FUNC_CHAR, CHAR_B_UPPER, 4'd0, 4'd0, 14'd0, 16'd0);
    send_word(FUNC_EMIT, 8'h00, 4'd0, 4'd0, 14'd5, 16'd16384);
  endtask

  task automatic test_ignored_codes;
    send_word(FUNC_CHAR, CHAR_M_LOWER, 4'd0, 4'd0, 14'd0, 16'd0);
    send_word(FUNC_CHAR, CHAR_M_UPPER, 4'd0, 4'd0, 14'd0, 16'd0);
    send_word(FUNC_CHAR, 8'hFF, 4'd15, 4'd15, 14'd16383, 16'd65535);
    send_word(FUNC_CHAR, 8'h00, 4'd0, 4'd0, 14'd0, 16'd0);
    send_word(FUNC_UNUSED, 8'hFF, 4'd15, 4'd15, 14'd16383, 16'd65535);
    send_word(FUNC_CHAR, CHAR_DIGIT_LO + 8'd3, 4'd0, 4'd0, 14'd0, 16'd0);
    send_word(FUNC_EMIT, 8'hFF, 4'd15, 4'd15, 14'd200, 16'd16383);
  endtask

  task automatic test_register_settings;
    logic [6:0] chans [RANDOM_PHASES];
    logic [6:0] vons  [RANDOM_PHASES];
    logic [6:0] voffs [RANDOM_PHASES];
    chans = '{7'd0, 7'd15, 7'd0, 7'($urandom_range(1, 14)), 7'($urandom_range(0, 15)), 7'd0};
    vons  = '{VON_RESET, 7'd127, 7'd0, 7'($urandom_range(1, 126)), 7'($urandom_range(0, 127)),
              VON_RESET};
    voffs = '{VOFF_RESET, 7'd127, 7'd0, 7'($urandom_range(1, 126)), 7'($urandom_range(0, 127)),
              VOFF_RESET};
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      if (ph > 0) begin
        write_reg(CFG_CHANNEL, chans[ph]);
        write_reg(CFG_VEL_ON, vons[ph]);
        write_reg(CFG_VEL_OFF, voffs[ph]);
      end
      // one phase runs with no idling on either side
      calm = (ph == 3);
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        send_random_word();
      end
    end
    calm = 1'b0;
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(32, 200);
      end else begin
        rx_left--;
      end
      rx_tick++;
      case (rx_mode)
        RX_OPEN:  m_axis_tready <= 1'b1;
        RX_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
        RX_CHOKE: m_axis_tready <= ($urandom_range(0, 5) == 0);
        default:  m_axis_tready <= (rx_tick % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    nme_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected event word, byte_count", int'(m_axis_tdata[83:80]), 0);
      end else begin
        want = pending_events.pop_front();
        for (int i = 0; i < NUM_BYTES; i++) begin
          if (m_axis_tdata[8*i +: 8] !== want.bytes[i]) begin
            report_mismatch($sformatf("byte%0d", i), m_axis_tdata[8*i +: 8], want.bytes[i]);
          end
        end
        if (m_axis_tdata[83:80] !== want.byte_count) begin
          report_mismatch("byte_count", m_axis_tdata[83:80], want.byte_count);
        end
      end
    end
  end

  initial begin
    clk           = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = FUNC_CHAR;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_CHANNEL;
    cfg_data_i    = '0;
    err_count     = 0;
    burst_left    = 0;
    calm          = 1'b0;
    rx_mode       = RX_OPEN;
    rx_left       = 0;
    rx_tick       = 0;
    row_st        = ROW_RESET;
    col_st        = COL_RESET;
    pitch_st      = PITCH_RESET;
    chan_cfg      = CHAN_RESET;
    von_cfg       = VON_RESET;
    voff_cfg      = VOFF_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    test_reset_state();
    test_pitch_limits();
    test_ignored_codes();
    test_register_settings();
    drain();

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
